// ===== design/bgr_to_ycbcr_420_converter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// bgr to ycbcr 4:2:0 converter - assertion macros
// shared property wrappers on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef BGR_TO_YCBCR_420_CONVERTER_UNIT_DEFINES_SVH
`define BGR_TO_YCBCR_420_CONVERTER_UNIT_DEFINES_SVH

// property that must hold in the same cycle
`define B2Y420_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies another in the next cycle
`define B2Y420_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/b2y420_pkg.sv =====
// ----------------------------------------------------------------------------
// b2y420_pkg
// types, register indexes and coefficients of the bgr to ycbcr 4:2:0 converter
// ----------------------------------------------------------------------------
`default_nettype none

package b2y420_pkg;

  localparam int unsigned MaxWidthDef    = 4096;
  localparam int unsigned MaxHeight      = 4096;
  localparam int unsigned RowW           = 12;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 13;
  localparam int unsigned ImgWidthReset  = 640;
  localparam int unsigned ImgHeightReset = 480;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;

  // luma coefficients
  localparam int unsigned CoefYR = 66;
  localparam int unsigned CoefYG = 129;
  localparam int unsigned CoefYB = 25;
  localparam int unsigned LumaOffset = 16;
  // cb = -38 r - 74 g + 112 b
  localparam int unsigned CoefCbR = 38;
  localparam int unsigned CoefCbG = 74;
  localparam int unsigned CoefCbB = 112;
  // cr = 112 r - 94 g - 18 b
  localparam int unsigned CoefCrR = 112;
  localparam int unsigned CoefCrG = 94;
  localparam int unsigned CoefCrB = 18;
  localparam int unsigned RoundHalf    = 128;
  localparam int unsigned ChromaOffset = 128;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       frame_end;
  } result_t;

  // horizontal pair sums, blue in the low bits
  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } pair_sum_t;

  // first stage contents handed to the arithmetic stages
  typedef struct packed {
    pixel_t    pix;
    pair_sum_t cur_sum;
    pair_sum_t prev_sum;
    logic      chroma;
    logic      self_row;
    logic      frame_end;
  } stage_t;

endpackage

`default_nettype wire

// ===== design/bgr_to_ycbcr_420_converter_unit.sv =====
// ----------------------------------------------------------------------------
// bgr_to_ycbcr_420_converter_unit
// bt.601 studio range bgr to ycbcr converter with 2x2 chroma subsampling
// ----------------------------------------------------------------------------
// Takes one BGR pixel per clock in raster order while not stalled and returns
// one result per pixel through registers s1, s2 and out: luma every pixel, Cb
// and Cr (with chroma_valid) at the second pixel of each pair on odd rows, and
// frame_end on the last pixel of the frame. The sustained rate is one pixel
// per cycle while the output is not stalled, set by the line buffer, which
// takes one pair-sum write and one read per pixel through its two ports; the
// three register stages each hold one pixel, so the input keeps flowing while
// the pipeline has an empty stage. The line buffer holds (MAX_WIDTH+1)/2 pair
// sums and needs no clearing after reset. Writing image_width or image_height
// restarts the frame at its first pixel; write them only while no pixel is in
// flight. Odd widths and heights pair the last column or row with itself.
`default_nettype none

module bgr_to_ycbcr_420_converter_unit #(
  parameter int unsigned MAX_WIDTH = b2y420_pkg::MaxWidthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [b2y420_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [b2y420_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire b2y420_pkg::pixel_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output b2y420_pkg::result_t                  out_data_o
);

  logic               s1_valid;
  logic               take;
  b2y420_pkg::stage_t s1;

  assign cfg_ready_o = 1'b1;

  b2y420_sampler #(
    .MaxWidth (MAX_WIDTH)
  ) u_sampler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .take_i      (take),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1)
  );

  b2y420_math u_math (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_i        (s1),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/b2y420_ram.sv =====
// ----------------------------------------------------------------------------
// b2y420_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module b2y420_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== design/b2y420_sampler.sv =====
// ----------------------------------------------------------------------------
// b2y420_sampler
// raster position, pair forming, line buffer access and the input register
// ----------------------------------------------------------------------------
`default_nettype none

module b2y420_sampler #(
  parameter int unsigned MaxWidth = b2y420_pkg::MaxWidthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic [b2y420_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [b2y420_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  input  wire b2y420_pkg::pixel_t              in_data_i,
  output logic                                 in_stall_o,
  input  wire logic                            take_i,
  output logic                                 s1_valid_o,
  output b2y420_pkg::stage_t                   s1_o
);

  localparam int unsigned ColW  = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned Pairs = (MaxWidth + 1) / 2;
  localparam int unsigned AddrW = (Pairs > 1) ? $clog2(Pairs) : 1;
  localparam int unsigned RowW  = b2y420_pkg::RowW;
  localparam int unsigned ResetWLast =
    ((b2y420_pkg::ImgWidthReset > MaxWidth) ? MaxWidth : b2y420_pkg::ImgWidthReset) - 1;
  localparam int unsigned ResetHLast =
    ((b2y420_pkg::ImgHeightReset > b2y420_pkg::MaxHeight) ?
      b2y420_pkg::MaxHeight : b2y420_pkg::ImgHeightReset) - 1;

  logic [ColW-1:0] wlast_q, wlast_d, wlast_cfg;
  logic [RowW-1:0] hlast_q, hlast_d, hlast_cfg;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  b2y420_pkg::pixel_t held_q;
  logic               s1_valid_q;
  logic               s1_en;
  logic               accept;
  logic               last_col, last_row, even_col, even_row;
  logic               hold_first, wr_en;
  b2y420_pkg::pixel_t partner;
  b2y420_pkg::pair_sum_t cur_sum, prev_sum;
  logic [AddrW-1:0]   pair_addr;

  typedef struct packed {
    b2y420_pkg::pixel_t    pix;
    b2y420_pkg::pair_sum_t cur_sum;
    logic                  chroma;
    logic                  self_row;
    logic                  frame_end;
  } s1_reg_t;

  s1_reg_t s1_q;

  // clamp written sizes to what the line buffer and row counter can hold
  always_comb begin
    if (cfg_data_i == '0) begin
      wlast_cfg = '0;
    end else if (14'(cfg_data_i) > 14'(MaxWidth)) begin
      wlast_cfg = ColW'(MaxWidth - 1);
    end else begin
      wlast_cfg = ColW'(cfg_data_i - 13'd1);
    end
    if (cfg_data_i == '0) begin
      hlast_cfg = '0;
    end else if (14'(cfg_data_i) > 14'(b2y420_pkg::MaxHeight)) begin
      hlast_cfg = RowW'(b2y420_pkg::MaxHeight - 1);
    end else begin
      hlast_cfg = RowW'(cfg_data_i - 13'd1);
    end
  end

  assign s1_en      = !s1_valid_q || take_i;
  assign accept     = in_valid_i && s1_en;
  assign in_stall_o = !s1_en;

  assign last_col   = (col_q == wlast_q);
  assign last_row   = (row_q == hlast_q);
  assign even_col   = !col_q[0];
  assign even_row   = !row_q[0];
  assign hold_first = even_col && !last_col;
  // odd width: the last pixel pairs with itself
  assign partner    = even_col ? in_data_i : held_q;

  assign cur_sum.blue  = {1'b0, partner.blue}  + {1'b0, in_data_i.blue};
  assign cur_sum.green = {1'b0, partner.green} + {1'b0, in_data_i.green};
  assign cur_sum.red   = {1'b0, partner.red}   + {1'b0, in_data_i.red};

  assign pair_addr = AddrW'(col_q >> 1);
  assign wr_en     = accept && !hold_first && even_row && !last_row;

  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    col_d   = col_q;
    row_d   = row_q;
    if (cfg_valid_i && (cfg_index_i == b2y420_pkg::RegImageWidth ||
                        cfg_index_i == b2y420_pkg::RegImageHeight)) begin
      if (cfg_index_i == b2y420_pkg::RegImageWidth) begin
        wlast_d = wlast_cfg;
      end else begin
        hlast_d = hlast_cfg;
      end
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q    <= ColW'(ResetWLast);
      hlast_q    <= RowW'(ResetHLast);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      wlast_q <= wlast_d;
      hlast_q <= hlast_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hold_first) begin
      held_q <= in_data_i;
    end
    if (accept) begin
      s1_q.pix       <= in_data_i;
      s1_q.cur_sum   <= cur_sum;
      s1_q.chroma    <= !hold_first && !(even_row && !last_row);
      s1_q.self_row  <= even_row;
      s1_q.frame_end <= last_col && last_row;
    end
  end

  // sums of the even row, read back on the odd row below
  b2y420_ram #(
    .Width ($bits(b2y420_pkg::pair_sum_t)),
    .Depth (Pairs),
    .AddrW (AddrW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (pair_addr),
    .wr_data_i (cur_sum),
    .rd_en_i   (accept),
    .rd_addr_i (pair_addr),
    .rd_data_o (prev_sum)
  );

  assign s1_valid_o       = s1_valid_q;
  assign s1_o.pix         = s1_q.pix;
  assign s1_o.cur_sum     = s1_q.cur_sum;
  assign s1_o.prev_sum    = prev_sum;
  assign s1_o.chroma      = s1_q.chroma;
  assign s1_o.self_row    = s1_q.self_row;
  assign s1_o.frame_end   = s1_q.frame_end;

endmodule

`default_nettype wire

// ===== design/b2y420_math.sv =====
// ----------------------------------------------------------------------------
// b2y420_math
// luma, 2x2 averaging and chroma matrix with the result register
// ----------------------------------------------------------------------------
`default_nettype none

module b2y420_math (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s1_valid_i,
  input  wire b2y420_pkg::stage_t  s1_i,
  output logic                     take_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output b2y420_pkg::result_t      out_data_o
);

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] avg_b;
    logic [7:0] avg_g;
    logic [7:0] avg_r;
    logic       chroma;
    logic       frame_end;
  } s2_t;

  logic s2_valid_q, out_valid_q;
  logic s2_en, out_en;
  s2_t  s2_q, s2_d;
  b2y420_pkg::result_t out_q, out_d;
  logic [9:0]  tot_b, tot_g, tot_r;
  logic [15:0] luma_acc;
  logic [17:0] cb_acc, cr_acc, cb_sh, cr_sh;

  assign out_en = !out_valid_q || !out_stall_i;
  assign s2_en  = !s2_valid_q || out_en;
  assign take_o = s2_en;

  // four-pixel totals; on an odd last row the pair is counted twice
  always_comb begin
    if (s1_i.self_row) begin
      tot_b = {s1_i.cur_sum.blue,  1'b0};
      tot_g = {s1_i.cur_sum.green, 1'b0};
      tot_r = {s1_i.cur_sum.red,   1'b0};
    end else begin
      tot_b = {1'b0, s1_i.cur_sum.blue}  + {1'b0, s1_i.prev_sum.blue};
      tot_g = {1'b0, s1_i.cur_sum.green} + {1'b0, s1_i.prev_sum.green};
      tot_r = {1'b0, s1_i.cur_sum.red}   + {1'b0, s1_i.prev_sum.red};
    end
    luma_acc = 16'(b2y420_pkg::CoefYR) * 16'(s1_i.pix.red)
             + 16'(b2y420_pkg::CoefYG) * 16'(s1_i.pix.green)
             + 16'(b2y420_pkg::CoefYB) * 16'(s1_i.pix.blue)
             + 16'(b2y420_pkg::RoundHalf);
    s2_d.luma      = 8'(luma_acc[15:8] + 8'(b2y420_pkg::LumaOffset));
    s2_d.avg_b     = 8'((tot_b + 10'd2) >> 2);
    s2_d.avg_g     = 8'((tot_g + 10'd2) >> 2);
    s2_d.avg_r     = 8'((tot_r + 10'd2) >> 2);
    s2_d.chroma    = s1_i.chroma;
    s2_d.frame_end = s1_i.frame_end;
  end

  // signed sums kept modulo 2^18, then floor shift
  always_comb begin
    cb_acc = 18'(b2y420_pkg::CoefCbB) * 18'(s2_q.avg_b)
           - 18'(b2y420_pkg::CoefCbR) * 18'(s2_q.avg_r)
           - 18'(b2y420_pkg::CoefCbG) * 18'(s2_q.avg_g)
           + 18'(b2y420_pkg::RoundHalf);
    cr_acc = 18'(b2y420_pkg::CoefCrR) * 18'(s2_q.avg_r)
           - 18'(b2y420_pkg::CoefCrG) * 18'(s2_q.avg_g)
           - 18'(b2y420_pkg::CoefCrB) * 18'(s2_q.avg_b)
           + 18'(b2y420_pkg::RoundHalf);
    cb_sh = 18'($signed(cb_acc) >>> 8);
    cr_sh = 18'($signed(cr_acc) >>> 8);
    out_d.luma         = s2_q.luma;
    out_d.chroma_valid = s2_q.chroma;
    out_d.frame_end    = s2_q.frame_end;
    if (s2_q.chroma) begin
      out_d.cb = cb_sh[7:0] + 8'(b2y420_pkg::ChromaOffset);
      out_d.cr = cr_sh[7:0] + 8'(b2y420_pkg::ChromaOffset);
    end else begin
      out_d.cb = 8'(b2y420_pkg::ChromaOffset);
      out_d.cr = 8'(b2y420_pkg::ChromaOffset);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_valid_q <= s1_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_i) begin
      s2_q <= s2_d;
    end
    if (out_en && s2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/b2y420_checker.sv =====
// ----------------------------------------------------------------------------
// b2y420_checker
// port level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "bgr_to_ycbcr_420_converter_unit_defines.svh"

module b2y420_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire b2y420_pkg::pixel_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire b2y420_pkg::result_t out_data_o
);

  logic in_wait, out_wait;
  logic luma_ok, neutral_ok, chroma_ok;

  assign in_wait    = in_valid_i && in_stall_o;
  assign out_wait   = out_valid_o && out_stall_i;
  assign luma_ok    = (out_data_o.luma >= 8'd16) && (out_data_o.luma <= 8'd235);
  assign neutral_ok = out_data_o.chroma_valid ||
                      (out_data_o.cb == 8'd128 && out_data_o.cr == 8'd128);
  assign chroma_ok  = !out_data_o.chroma_valid ||
                      (out_data_o.cb >= 8'd16 && out_data_o.cb <= 8'd240 &&
                       out_data_o.cr >= 8'd16 && out_data_o.cr <= 8'd240);

  // a stalled pixel beat stays put
  `B2Y420_ASSERT_NEXT(a_in_hold, in_wait, in_valid_i && $stable(in_data_i), "pixel beat moved")

  // a stalled beat stays put
  `B2Y420_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_data_o), "result beat moved")

  // luma lies in studio range
  `B2Y420_ASSERT(a_luma_range, !out_valid_o || luma_ok, "luma out of range")

  // no finished block means neutral chroma
  `B2Y420_ASSERT(a_chroma_neutral, !out_valid_o || neutral_ok, "chroma not neutral without a block")

  // finished chroma lies in studio range
  `B2Y420_ASSERT(a_chroma_range, !out_valid_o || chroma_ok, "chroma out of range")

endmodule

bind bgr_to_ycbcr_420_converter_unit b2y420_checker u_b2y420_checker (.*);

`default_nettype wire
